>>> hdl/rle_literal_run_encoder_macros.svh
// Assertion macros used by the checker file
`ifndef RLE_LITERAL_RUN_ENCODER_MACROS_SVH
`define RLE_LITERAL_RUN_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RLE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rle check failed");

// Next-cycle implication, disabled during reset
`define RLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rle check failed");

`endif

>>> hdl/rle_pkg.sv
package rle_pkg;

  localparam int MAX_PACKET_DEF   = 127;
  localparam int ELEMENT_BITS_DEF = 32;
  localparam int WIN_DEPTH        = 128;
  localparam int WIN_AW           = 7;
  localparam int PEND_W           = 8;
  localparam int LEN_W            = 7;
  localparam int CFG_DATA_W       = 7;
  localparam int CFG_IDX_W        = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN       = 1'd1;

  localparam logic [2:0]       ELEMENT_BYTES_RST = 3'd4;
  localparam logic [LEN_W-1:0] MIN_RUN_RST       = 7'd2;

  // request codes
  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic base;
    logic cmp;
    logic emit;
  } rle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic proc;
    logic done_base;
    logic done_cmp;
    logic out_free;
  } rle_stat_t;

endpackage

>>> hdl/rle_if.sv
interface rle_in_if #(parameter int ELEMENT_BITS = rle_pkg::ELEMENT_BITS_DEF);
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [ELEMENT_BITS-1:0] element;
  logic                    end_of_data;
  modport source (output valid, req_type, element, end_of_data, input ready);
  modport sink (input valid, req_type, element, end_of_data, output ready);
endinterface

interface rle_out_if #(parameter int ELEMENT_BITS = rle_pkg::ELEMENT_BITS_DEF);
  logic                    valid;
  logic                    ready;
  logic                    with_header;
  logic [7:0]              header_byte;
  logic [ELEMENT_BITS-1:0] element_out;
  logic                    last;
  modport source (output valid, with_header, header_byte, element_out, last, input ready);
  modport sink (input valid, with_header, header_byte, element_out, last, output ready);
endinterface

>>> hdl/rle_ctrl.sv
module rle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rle_pkg::rle_stat_t stat,
  output rle_pkg::rle_cmd_t  cmd
);

  typedef enum logic [4:0] {
    IDLE = 5'b00001,
    LOAD = 5'b00010,
    BASE = 5'b00100,
    CMP  = 5'b01000,
    EMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencing of one packet element
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.proc) state_next = LOAD;
        end
      end
      LOAD: begin
        cmd.load   = 1'b1;
        state_next = BASE;
      end
      BASE: begin
        cmd.base   = 1'b1;
        state_next = stat.done_base ? EMIT : CMP;
      end
      CMP: begin
        cmd.cmp = 1'b1;
        if (stat.done_cmp) state_next = EMIT;
      end
      EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

endmodule

>>> hdl/rle_dpath.sv
module rle_dpath #(
  parameter int MAX_PACKET   = rle_pkg::MAX_PACKET_DEF,
  parameter int ELEMENT_BITS = rle_pkg::ELEMENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rle_pkg::rle_cmd_t                 cmd,
  output rle_pkg::rle_stat_t                stat,
  input  logic                              req_type,
  input  logic [ELEMENT_BITS-1:0]           element,
  input  logic                              end_of_data,
  input  logic                              cfg_we,
  input  logic [rle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rle_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              with_header,
  output logic [7:0]                        header_byte,
  output logic [ELEMENT_BITS-1:0]           element_out,
  output logic                              last
);

  localparam int AW = rle_pkg::WIN_AW;
  localparam int PW = rle_pkg::PEND_W;
  localparam int LW = rle_pkg::LEN_W;

  logic [ELEMENT_BITS-1:0] mem [rle_pkg::WIN_DEPTH];
  logic [ELEMENT_BITS-1:0] rdata, base, mask;
  logic [AW-1:0]           rd_addr, start;
  logic [PW-1:0]           pending, pending_after;
  logic [LW-1:0]           remaining, r, hits, runlen, len, min_run, k;
  logic [2:0]              element_bytes, nb;
  logic                    ended, run_active, hdr_on, is_lit;
  logic                    push_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      element_bytes <= rle_pkg::ELEMENT_BYTES_RST;
      min_run       <= rle_pkg::MIN_RUN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rle_pkg::REG_ELEMENT_BYTES: element_bytes <= cfg_data[2:0];
        rle_pkg::REG_MIN_RUN:       min_run       <= cfg_data;
        default: ;
      endcase
    end
  end

  // significant-byte mask, width clamped to 1..4 bytes
  always_comb begin
    priority if (element_bytes == 3'd0) nb = 3'd1;
    else if (element_bytes > 3'd4) nb = 3'd4;
    else nb = element_bytes;
    for (int i = 0; i < ELEMENT_BITS; i++) begin
      mask[i] = (i / 8) < int'(nb);
    end
  end

  assign push_ok = (req_type == rle_pkg::REQ_PUSH) && !ended &&
                   (pending < PW'(MAX_PACKET));

  // window memory, one write and one registered read
  always_comb begin
    priority if (cmd.base) rd_addr = start + AW'(1);
    else if (cmd.cmp) rd_addr = start + r + AW'(1);
    else rd_addr = start;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && push_ok) mem[start + pending[AW-1:0]] <= element;
    rdata <= mem[rd_addr];
  end

  // scan step on the element at offset r
  logic          eq, ra_n, last_step, run_done, lit_break;
  logic [LW-1:0] hits_n, runlen_n;

  always_comb begin
    eq        = (rdata & mask) == base;
    hits_n    = eq ? hits + LW'(1) : '0;
    ra_n      = run_active && eq;
    runlen_n  = ra_n ? r + LW'(1) : runlen;
    last_step = ({1'b0, r} + PW'(1)) == pending;
    run_done  = (runlen_n > min_run) && (!ra_n || last_step);
    lit_break = !run_done && !ra_n && (hits_n > min_run);
  end

  // status to the controller; proc tells whether the accepted item yields a result
  always_comb begin
    if (req_type == rle_pkg::REQ_PUSH) begin
      stat.proc = push_ok && (pending == PW'(MAX_PACKET - 1));
    end else begin
      stat.proc = ended && (pending != '0);
    end
    stat.done_base = (remaining != '0) || (pending == PW'(1));
    stat.done_cmp  = run_done || lit_break || last_step;
    stat.out_free  = !out_valid || out_ready;
  end

  // scan registers and packet decision
  always_ff @(posedge clk) begin
    if (cmd.base) begin
      base       <= rdata & mask;
      r          <= LW'(1);
      hits       <= '0;
      run_active <= 1'b1;
      runlen     <= LW'(1);
      hdr_on     <= remaining == '0;
      is_lit     <= min_run != '0;
      len        <= LW'(1);
    end else if (cmd.cmp) begin
      r          <= r + LW'(1);
      hits       <= hits_n;
      run_active <= ra_n;
      runlen     <= runlen_n;
      priority if (run_done) begin
        is_lit <= 1'b0;
        len    <= runlen_n;
      end else if (lit_break) begin
        is_lit <= 1'b1;
        len    <= r - hits_n + LW'(1);
      end else begin
        is_lit <= 1'b1;
        len    <= pending[LW-1:0];
      end
    end
  end

  // elements consumed by this result
  always_comb begin
    k             = (hdr_on && !is_lit) ? len : LW'(1);
    pending_after = pending - PW'(k);
  end

  // window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      start     <= '0;
      remaining <= '0;
      ended     <= 1'b0;
    end else if (cmd.accept && push_ok) begin
      pending <= pending + PW'(1);
      if (end_of_data) ended <= 1'b1;
    end else if (cmd.emit) begin
      pending <= pending_after;
      start   <= start + k;
      if (ended && pending_after == '0) begin
        ended     <= 1'b0;
        remaining <= '0;
      end else if (hdr_on) begin
        remaining <= is_lit ? len - LW'(1) : '0;
      end else begin
        remaining <= remaining - LW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      with_header <= hdr_on;
      header_byte <= hdr_on ? {is_lit, len} : 8'd0;
      element_out <= base;
      last        <= ended && (pending_after == '0);
    end
  end

endmodule

>>> hdl/rle_literal_run_encoder.sv
// Run-length encoder with literal packets over a 128-entry element window.
// A push that does not fill the window is taken in the idle state. An item
// that yields a result passes through the load, base and emit states, the
// emit state waiting for the output register to be free; the first element
// of a packet, unless it is the only pending element, also passes through the
// compare state, which scans the pending elements after it (up to the pending count
// less one), one element a cycle. The result sits in an output register, so a stalled sink holds back only
// the next result. Configuration is to be written only while the block is idle; the block does not enforce this.
module rle_literal_run_encoder #(
  parameter int MAX_PACKET   = rle_pkg::MAX_PACKET_DEF,
  parameter int ELEMENT_BITS = rle_pkg::ELEMENT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  rle_in_if.sink                         in_ch,
  rle_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rle_pkg::CFG_DATA_W-1:0] cfg_data
);

  rle_pkg::rle_cmd_t  cmd;
  rle_pkg::rle_stat_t stat;

  rle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rle_dpath #(
    .MAX_PACKET   (MAX_PACKET),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (in_ch.req_type),
    .element     (in_ch.element),
    .end_of_data (in_ch.end_of_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .with_header (out_ch.with_header),
    .header_byte (out_ch.header_byte),
    .element_out (out_ch.element_out),
    .last        (out_ch.last)
  );

endmodule

>>> hdl/rle_checker.sv
`include "rle_literal_run_encoder_macros.svh"

module rle_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       with_header,
  input logic [7:0] header_byte
);

  // a waiting result is not withdrawn
  `RLE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // element without a header carries a zero header byte
  `RLE_ASSERT_NOW(a_hdr_zero, clk, rst, out_valid && !with_header, header_byte == 8'd0)

  // every header gives a packet length of at least one
  `RLE_ASSERT_NOW(a_hdr_len, clk, rst, out_valid && with_header, header_byte[6:0] != 7'd0)

endmodule

bind rle_literal_run_encoder rle_checker u_rle_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .with_header (out_ch.with_header),
  .header_byte (out_ch.header_byte)
);

>>> verif/rle_literal_run_encoder_tb.sv
module rle_literal_run_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_LIMIT   = 127;
  localparam int SETTLE      = 400;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic        req;
    logic [31:0] elem;
    logic        eod;
  } push_item_t;

  typedef struct {
    logic        with_header;
    logic [7:0]  header_byte;
    logic [31:0] element_out;
    logic        last;
  } packet_out_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [rle_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rle_pkg::CFG_DATA_W-1:0] cfg_data;

  rle_in_if  in_ch();
  rle_out_if out_ch();

  rle_literal_run_encoder u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // stimulus and expectations
  push_item_t  item_q[$];
  packet_out_t packet_q[$];
  int          mismatches;
  int          idle_mode;
  int          hold_cnt;
  logic        hold_go;
  logic        hold_done;
  longint      cycles;

  // encoder shadow state
  logic [2:0]  sh_bytes;
  logic [6:0]  sh_min_run;
  logic [31:0] sh_win [128];
  int          sh_pending;
  int          sh_start;
  int          sh_remaining;
  logic        sh_ended;

  function automatic logic [31:0] byte_mask();
    int nb;
    nb = sh_bytes;
    if (nb < 1) nb = 1;
    if (nb > 4) nb = 4;
    return (nb == 4) ? 32'hFFFF_FFFF : ((32'h1 << (nb * 8)) - 1);
  endfunction

  function automatic bit elem_match(int a, int b, logic [31:0] m);
    return ((sh_win[a & 127] ^ sh_win[b & 127]) & m) == 0;
  endfunction

  function automatic void advance(int k);
    if (k > sh_pending) k = sh_pending;
    sh_start = (sh_start + k) & 127;
    sh_pending -= k;
  endfunction

  // emit the oldest pending element, starting a packet when none is open
  function automatic void emit_packet_item();
    logic [31:0] m;
    int          s;
    int          lim;
    int          r;
    int          hits;
    packet_out_t p;
    m = byte_mask();
    s = sh_start;
    p.with_header = 1'b0;
    p.header_byte = 8'h00;
    p.element_out = sh_win[s & 127] & m;
    p.last = 1'b0;
    if (sh_remaining == 0) begin
      lim = (sh_pending > WIN_LIMIT) ? WIN_LIMIT : sh_pending;
      r = 1;
      while (r < lim && elem_match(s, s + r, m)) r++;
      if (r <= sh_min_run) begin
        // literal: stop just before a long stretch equal to the start
        hits = 0;
        for (r = 1; r < lim; r++) begin
          if (!elem_match(s, s + r, m)) begin
            hits = 0;
          end else begin
            hits++;
            if (hits > sh_min_run) begin
              r -= hits - 1;
              break;
            end
          end
        end
        p.header_byte = 8'h80 | 8'(r & 7'h7F);
        sh_remaining = r - 1;
        advance(1);
      end else begin
        p.header_byte = 8'(r & 7'h7F);
        sh_remaining = 0;
        advance(r);
      end
      p.with_header = 1'b1;
    end else begin
      sh_remaining--;
      advance(1);
    end
    if (sh_ended && sh_pending == 0) begin
      p.last = 1'b1;
      sh_ended = 1'b0;
      sh_remaining = 0;
    end
    packet_q.push_back(p);
  endfunction

  function automatic void predict(push_item_t it);
    if (it.req == rle_pkg::REQ_PUSH) begin
      if (sh_ended || sh_pending >= WIN_LIMIT) return;
      sh_win[(sh_start + sh_pending) & 127] = it.elem;
      sh_pending++;
      if (it.eod) sh_ended = 1'b1;
      if (sh_pending >= WIN_LIMIT) emit_packet_item();
    end else if (sh_ended && sh_pending != 0) begin
      emit_packet_item();
    end
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict('{in_ch.req_type, in_ch.element, in_ch.end_of_data});
      if (!in_ch.valid || in_ch.ready) begin
        if (item_q.size() != 0 &&
            !((idle_mode == 1 && $urandom_range(0, 99) < 54) ||
              (idle_mode == 3 && $urandom_range(0, 99) < 9))) begin
          in_ch.valid       <= 1'b1;
          in_ch.req_type    <= item_q[0].req;
          in_ch.element     <= item_q[0].elem;
          in_ch.end_of_data <= item_q[0].eod;
          void'(item_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_done) begin
      hold_cnt  <= 1500;
      hold_done <= 1'b1;
    end
  end

  // receiver ready and result check
  always @(posedge clk) begin
    packet_out_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (hold_cnt == 0) &&
        !((idle_mode == 2 && $urandom_range(0, 99) < 54) ||
          (idle_mode == 3 && $urandom_range(0, 99) < 9));
      if (out_ch.valid && out_ch.ready) begin
        if (packet_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: hdr_on=%0d hdr=%02h elem=%08h last=%0d",
                     out_ch.with_header, out_ch.header_byte, out_ch.element_out,
                     out_ch.last);
        end else begin
          e = packet_q.pop_front();
          if (out_ch.with_header !== e.with_header || out_ch.header_byte !== e.header_byte ||
              out_ch.element_out !== e.element_out || out_ch.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d/%02h/%08h/%0d got %0d/%02h/%08h/%0d",
                       e.with_header, e.header_byte, e.element_out, e.last,
                       out_ch.with_header, out_ch.header_byte, out_ch.element_out,
                       out_ch.last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL rle_literal_run_encoder");
      $finish;
    end
  end

  task automatic wait_idle();
    while (item_q.size() != 0 || in_ch.valid || packet_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [rle_pkg::CFG_IDX_W-1:0] idx,
                           logic [rle_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rle_pkg::REG_ELEMENT_BYTES) sh_bytes = val[2:0];
    else sh_min_run = val[6:0];
  endtask

  function automatic void add(logic req, logic [31:0] elem, logic eod);
    item_q.push_back('{req, elem, eod});
  endfunction

  // one stream: runs, small alphabets and noise, then its drains
  function automatic void add_stream(int len);
    logic [31:0] pool [4];
    logic [31:0] v;
    int          sel;
    v = $urandom;
    for (int k = 0; k < 4; k++) pool[k] = $urandom;
    if ($urandom_range(0, 9) == 0) add(rle_pkg::REQ_DRAIN, $urandom, 1'b0);
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        // repeat previous
      end else if (sel < 8) begin
        v = pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 1) != 0) v[31:8] = 24'($urandom);
      end else begin
        v = $urandom;
      end
      add(rle_pkg::REQ_PUSH, v, (i == len - 1) || ($urandom_range(0, 299) == 0));
    end
    if ($urandom_range(0, 4) == 0) add(rle_pkg::REQ_PUSH, $urandom, 1'b0);
    for (int i = 0; i < ((len > WIN_LIMIT) ? WIN_LIMIT : len) + 2; i++)
      add(rle_pkg::REQ_DRAIN, $urandom, 1'($urandom_range(0, 1)));
  endfunction

  // n_items counts every queued item, pushes and drains alike
  task automatic run_phase(int nbytes, int mrun, int mode, int n_items, bit pressure);
    int q0;
    int len;
    wait_idle();
    write_reg(rle_pkg::REG_ELEMENT_BYTES, rle_pkg::CFG_DATA_W'(nbytes));
    write_reg(rle_pkg::REG_MIN_RUN, rle_pkg::CFG_DATA_W'(mrun));
    idle_mode = mode;
    q0 = item_q.size();
    if (pressure) begin
      hold_go <= 1'b1;
      add_stream(150);
    end
    while (item_q.size() - q0 < n_items) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(128, 200) : $urandom_range(1, 60);
      add_stream(len);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = rle_pkg::REQ_PUSH;
    in_ch.element = '0;
    in_ch.end_of_data = 1'b0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    idle_mode = 0;
    hold_go = 1'b0;
    cycles = 0;
    sh_bytes = rle_pkg::ELEMENT_BYTES_RST;
    sh_min_run = rle_pkg::MIN_RUN_RST;
    sh_pending = 0;
    sh_start = 0;
    sh_remaining = 0;
    sh_ended = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: drain before end, run, extremes, literal, push after end
    add(rle_pkg::REQ_DRAIN, 32'h0, 1'b0);
    repeat (4) add(rle_pkg::REQ_PUSH, 32'h0000_0000, 1'b0);
    add(rle_pkg::REQ_PUSH, 32'hFFFF_FFFF, 1'b0);
    add(rle_pkg::REQ_PUSH, 32'h0000_0001, 1'b0);
    add(rle_pkg::REQ_PUSH, 32'hFFFF_FFFF, 1'b0);
    add(rle_pkg::REQ_PUSH, 32'hFFFF_FFFF, 1'b0);
    repeat (3) add(rle_pkg::REQ_PUSH, 32'h0000_0007, 1'b0);
    add(rle_pkg::REQ_PUSH, 32'h0000_0005, 1'b1);
    add(rle_pkg::REQ_PUSH, 32'h1234_5678, 1'b0);
    repeat (12) add(rle_pkg::REQ_DRAIN, 32'hFFFF_FFFF, 1'b1);

    run_phase(1, 1, 0, 90, 1'b0);
    run_phase(2, 126, 1, 90, 1'b0);
    run_phase(3, 0, 2, 90, 1'b0);
    run_phase(0, 127, 3, 0, 1'b1);
    run_phase(7, 5, 0, 90, 1'b0);
    run_phase(4, 2, 2, 90, 1'b0);
    wait_idle();

    if (mismatches == 0) begin
      $display("PASS rle_literal_run_encoder");
    end else begin
      $display("FAIL rle_literal_run_encoder");
    end
    $finish;
  end
endmodule

>>> rle_literal_run_encoder.f
+incdir+hdl
hdl/rle_pkg.sv
hdl/rle_if.sv
hdl/rle_ctrl.sv
hdl/rle_dpath.sv
hdl/rle_literal_run_encoder.sv
hdl/rle_checker.sv
verif/rle_literal_run_encoder_tb.sv
